// File: hdl/rkd_pkg.sv
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types, codes and constants of the rotary knob decoder.
// ----------------------------------------------------------------------------
package rkd_pkg;

  localparam int RKD_KNOBS = 2;
  localparam int SLOTS     = 5;

  // encoder_type codes
  localparam logic [1:0] ENC_HALF  = 2'd0;
  localparam logic [1:0] ENC_FULL  = 2'd1;
  localparam logic [1:0] ENC_THREE = 2'd2;
  localparam logic [1:0] ENC_DET   = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TYPE   = 2'd0;
  localparam logic [1:0] REG_FILTER = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [2:0] CODE_ALL   = 3'h7;
  localparam logic [2:0] CODE_IDLE2 = 3'h1;

  localparam logic [15:0] FILTER_RST = 16'd3;
  localparam logic [15:0] HOLD_RST   = 16'd1000;

  typedef logic [2:0] code_t;

  // per-knob decoder state, one memory word
  typedef struct packed {
    logic [15:0]           hold;
    code_t                 prev;
    code_t [SLOTS-1:0]     hist;
    logic [7:0]            up;
    logic [7:0]            down;
  } entry_t;

  // last reported values, one memory word
  typedef struct packed {
    logic [7:0] up;
    logic [7:0] down;
    logic [1:0] dir;
  } rep_t;

  typedef struct packed {
    logic [1:0]  enc_type;
    logic [15:0] filter_time;
    logic [15:0] max_hold;
  } cfg_t;

endpackage

// File: hdl/rkd_ram.sv
// ----------------------------------------------------------------------------
// rkd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rkd_update.sv
// ----------------------------------------------------------------------------
// rkd_update
// Debounce, history shift and detent judge for one knob word.
// ----------------------------------------------------------------------------
module rkd_update
  import rkd_pkg::*;
(
  input  entry_t cur,
  input  cfg_t   cfg,
  input  logic   pin_a,
  input  logic   pin_b,
  input  logic   pin_c,
  output entry_t nxt
);

  // returns {up, down} detent hit on a history
  function automatic logic [1:0] judge(input logic [1:0] enc, input code_t [SLOTS-1:0] h);
    logic up_hit;
    logic dn_hit;
    up_hit = 1'b0;
    dn_hit = 1'b0;
    case (enc)
      ENC_HALF: begin
        if (h[0] == 3'd0 && h[1] == 3'd1 && h[2] == 3'd3) dn_hit = 1'b1;
        else if (h[0] == 3'd0 && h[1] == 3'd2 && h[2] == 3'd3) up_hit = 1'b1;
        else if (h[0] == 3'd3 && h[1] == 3'd1 && h[2] == 3'd0) up_hit = 1'b1;
        else if (h[0] == 3'd3 && h[1] == 3'd2 && h[2] == 3'd0) dn_hit = 1'b1;
      end
      ENC_FULL: begin
        if (h[0] == 3'd3 && h[1] == 3'd1 && h[2] == 3'd0 && h[3] == 3'd2 && h[4] == 3'd3)
          dn_hit = 1'b1;
        else if (h[0] == 3'd3 && h[1] == 3'd2 && h[2] == 3'd0 && h[3] == 3'd1 &&
                 h[4] == 3'd3)
          up_hit = 1'b1;
      end
      ENC_THREE: begin
        if (h[1] == CODE_ALL) begin
          if ((h[0] == 3'd6 && h[2] == 3'd5) || (h[0] == 3'd5 && h[2] == 3'd3) ||
              (h[0] == 3'd3 && h[2] == 3'd6))
            up_hit = 1'b1;
          else if ((h[0] == 3'd6 && h[2] == 3'd3) || (h[0] == 3'd5 && h[2] == 3'd6) ||
                   (h[0] == 3'd3 && h[2] == 3'd5))
            dn_hit = 1'b1;
        end
      end
      default: begin
        if (h[0] == 3'd3 && h[1] == 3'd1 && h[2] == 3'd3) up_hit = 1'b1;
        else if (h[0] == 3'd3 && h[1] == 3'd2 && h[2] == 3'd3) dn_hit = 1'b1;
      end
    endcase
    return {up_hit, dn_hit};
  endfunction

  code_t      code;
  logic [2:0] newest;
  logic       check;
  logic       take;
  logic [1:0] hit;

  always_comb begin
    code   = (cfg.enc_type == ENC_THREE) ? {pin_a, pin_b, pin_c} : {1'b0, pin_a, pin_b};
    newest = (cfg.enc_type == ENC_FULL) ? 3'd4 : 3'd2;
    nxt    = cur;
    check  = 1'b1;
    hit    = 2'b00;

    if (code == cur.prev) begin
      if (cur.hold < cfg.max_hold) begin
        nxt.hold = cur.hold + 16'd1;
      end else begin
        // stuck transition: force newest slot, skip acceptance
        case (cfg.enc_type)
          ENC_FULL: begin
            if (code != 3'd3) begin
              nxt.hist[newest] = 3'd3;
              check = 1'b0;
            end
          end
          ENC_THREE: begin
            if (code == CODE_ALL) begin
              nxt.hist[newest] = 3'd0;
              check = 1'b0;
            end
          end
          default: begin
            if (code == 3'd1 || code == 3'd2) begin
              nxt.hist[newest] = 3'd0;
              check = 1'b0;
            end
          end
        endcase
      end
    end else begin
      nxt.hold = 16'd1;
      nxt.prev = code;
    end

    take = check && (nxt.hold >= cfg.filter_time) && (code != cur.hist[newest]);

    if (take) begin
      for (int s = 0; s < SLOTS - 1; s++) begin
        if (3'(s) < newest) nxt.hist[s] = cur.hist[s+1];
      end
      nxt.hist[newest] = code;
      hit = judge(cfg.enc_type, nxt.hist);
      if (hit[1]) begin
        if (cur.up != 8'hFF) nxt.up = cur.up + 8'd1;
        nxt.down = 8'd0;
      end else if (hit[0]) begin
        if (cur.down != 8'hFF) nxt.down = cur.down + 8'd1;
        nxt.up = 8'd0;
      end
    end
  end

endmodule

// File: hdl/rotary_knob_decoder_core.sv
// Sample path: the state word is read when a sample is accepted, then
// modified and written back in ST_SAMP. A report pass visits ST_REP_RD
// then ST_REP_OUT for each knob, waiting in ST_REP_OUT while the output
// stalls; each entry is loaded into the output register from ST_REP_OUT.
// Input words: one at a time, in_stall is high outside ST_IDLE.
// Reset: synchronous; knob entries read as cleared via valid bits, no sweep.
// ----------------------------------------------------------------------------
// rotary_knob_decoder_core
// Multi-knob rotary encoder decoder with memory-held per-knob state.
// ----------------------------------------------------------------------------
module rotary_knob_decoder_core
  import rkd_pkg::*;
#(
  parameter int KNOBS = RKD_KNOBS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [2:0]  in_knob,
  input  logic        in_pin_a,
  input  logic        in_pin_b,
  input  logic        in_pin_c,
  input  logic        in_voltage_fault,
  // report words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_knob_index,
  output logic [7:0]  out_up_count,
  output logic [7:0]  out_down_count,
  output logic [1:0]  out_direction,
  output logic        out_last,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (KNOBS > 1) ? $clog2(KNOBS) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SAMP    = 2'd1; // state word arrives, write back
  localparam logic [1:0] ST_REP_RD  = 2'd2; // issue read for knob idx_r
  localparam logic [1:0] ST_REP_OUT = 2'd3; // emit entry, clear tallies unless in fault

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TYPE:   cfg_nxt.enc_type    = cfg_pwdata[1:0];
        REG_FILTER: cfg_nxt.filter_time = cfg_pwdata[15:0];
        REG_HOLD:   cfg_nxt.max_hold    = cfg_pwdata[15:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TYPE:   cfg_prdata = {30'd0, cfg_r.enc_type};
      REG_FILTER: cfg_prdata = {16'd0, cfg_r.filter_time};
      REG_HOLD:   cfg_prdata = {16'd0, cfg_r.max_hold};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             running_r, running_nxt;
  logic             fault_r, fault_nxt;
  code_t            init_r, init_nxt;     // reset code latched at last clear
  logic [KNOBS-1:0] st_vld_r, st_vld_nxt; // state word written since clear
  logic [KNOBS-1:0] rep_vld_r, rep_vld_nxt;

  // captured sample pins (payload, no reset)
  logic pin_a_r, pin_b_r, pin_c_r;

  logic in_acc;
  logic in_range;
  logic is_last;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign in_range = ({1'b0, in_knob} < 4'(KNOBS));
  assign is_last  = (idx_r == AW'(KNOBS - 1));

  // --------------------------------------------------------------------------
  // Memories: per-knob decoder state and last reported entry
  // --------------------------------------------------------------------------
  logic          st_we, st_re;
  logic [AW-1:0] st_raddr;
  entry_t        st_wdata, st_rdata, st_cur, st_upd;
  logic          rep_we;
  rep_t          rep_wdata, rep_rdata, rep_cur;

  rkd_ram #(.WIDTH($bits(entry_t)), .DEPTH(KNOBS), .AW(AW)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx_r),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rkd_ram #(.WIDTH($bits(rep_t)), .DEPTH(KNOBS), .AW(AW)) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr (idx_r),
    .wdata (rep_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (rep_rdata)
  );

  // read issued on any accept in idle or in ST_REP_RD
  assign st_re    = in_acc | (state_r == ST_REP_RD);
  assign st_raddr = (state_r == ST_IDLE) ? in_knob[AW-1:0] : idx_r;

  // entries never written since clear read as the clear values
  always_comb begin
    if (st_vld_r[idx_r]) begin
      st_cur = st_rdata;
    end else begin
      st_cur.hold = 16'd0;
      st_cur.prev = init_r;
      st_cur.hist = {SLOTS{init_r}};
      st_cur.up   = 8'd0;
      st_cur.down = 8'd0;
    end
    rep_cur = rep_vld_r[idx_r] ? rep_rdata : '0;
  end

  rkd_update u_update (
    .cur   (st_cur),
    .cfg   (cfg_r),
    .pin_a (pin_a_r),
    .pin_b (pin_b_r),
    .pin_c (pin_c_r),
    .nxt   (st_upd)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, out_load;
  logic [2:0] knob_out_r;
  rep_t       rep_out_r, rep_out;
  logic       last_out_r;

  assign out_free = ~out_valid_r | ~out_stall;
  assign out_load = (state_r == ST_REP_OUT) & out_free;

  always_comb begin
    rep_out.up   = st_cur.up;
    rep_out.down = st_cur.down;
    if (st_cur.up != 8'd0)        rep_out.dir = DIR_UP;
    else if (st_cur.down != 8'd0) rep_out.dir = DIR_DOWN;
    else                          rep_out.dir = DIR_NONE;
    if (fault_r) rep_out = rep_cur; // fault: repeat previous report
  end

  assign out_valid_nxt  = out_load | (out_valid_r & out_stall);
  assign out_valid      = out_valid_r;
  assign out_knob_index = knob_out_r;
  assign out_up_count   = rep_out_r.up;
  assign out_down_count = rep_out_r.down;
  assign out_direction  = rep_out_r.dir;
  assign out_last       = last_out_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    running_nxt = running_r;
    fault_nxt   = fault_r;
    init_nxt    = init_r;
    st_vld_nxt  = st_vld_r;
    rep_vld_nxt = rep_vld_r;
    st_we       = 1'b0;
    st_wdata    = st_upd;
    rep_we      = 1'b0;
    rep_wdata   = rep_out;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_kind) begin
            // samples dropped until running or for absent knobs
            if (running_r && in_range) begin
              idx_nxt   = in_knob[AW-1:0];
              state_nxt = ST_SAMP;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_REP_RD;
            fault_nxt = in_voltage_fault;
            if (in_voltage_fault) begin
              running_nxt = 1'b0;
              st_vld_nxt  = '0;
              init_nxt    = (cfg_r.enc_type == ENC_THREE) ? CODE_ALL : CODE_IDLE2;
            end else begin
              running_nxt = 1'b1;
            end
          end
        end
      end
      ST_SAMP: begin
        st_we             = 1'b1;
        st_vld_nxt[idx_r] = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_REP_RD: begin
        state_nxt = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        if (out_free) begin
          if (!fault_r) begin
            st_wdata          = st_cur;
            st_wdata.up       = 8'd0;
            st_wdata.down     = 8'd0;
            st_we             = 1'b1;
            st_vld_nxt[idx_r] = 1'b1;
            rep_we             = 1'b1;
            rep_vld_nxt[idx_r] = 1'b1;
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_REP_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      running_r   <= 1'b0;
      fault_r     <= 1'b0;
      init_r      <= CODE_IDLE2;
      st_vld_r    <= '0;
      rep_vld_r   <= '0;
      out_valid_r <= 1'b0;
      cfg_r.enc_type    <= ENC_HALF;
      cfg_r.filter_time <= FILTER_RST;
      cfg_r.max_hold    <= HOLD_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      running_r   <= running_nxt;
      fault_r     <= fault_nxt;
      init_r      <= init_nxt;
      st_vld_r    <= st_vld_nxt;
      rep_vld_r   <= rep_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pin_a_r <= in_pin_a;
      pin_b_r <= in_pin_b;
      pin_c_r <= in_pin_c;
    end
    if (out_load) begin
      knob_out_r <= 3'(idx_r);
      rep_out_r  <= rep_out;
      last_out_r <= is_last;
    end
  end

`ifndef SYNTHESIS
  // state memory is written only by the sample write-back or a report pass
  a_st_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == ST_SAMP || state_r == ST_REP_OUT))
    else $error("state memory written outside write-back");

  // a sample write-back only happens while running
  a_samp_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMP) |-> running_r)
    else $error("sample processed while not running");

  // a fault report clears every knob entry at once
  a_fault_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind && in_voltage_fault) |=> (st_vld_r == '0 && !running_r))
    else $error("fault report did not clear decoder state");

  // a pending report word is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(rep_out_r) &&
                                    $stable(knob_out_r)))
    else $error("stalled report word lost");
`endif

endmodule
